[rtl/core/prefix_sum_search_tree_assert.svh]
// ----------------------------------------------------------------------------
// prefix sum search tree assertion macros
// clocked property shorthands used by prefix_sum_search_tree
// ----------------------------------------------------------------------------
`ifndef PREFIX_SUM_SEARCH_TREE_ASSERT_SVH
`define PREFIX_SUM_SEARCH_TREE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PSST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define PSST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/psst_pkg.sv]
// ----------------------------------------------------------------------------
// psst_pkg
// sizes, beat payload types and shared unit types of the prefix sum tree
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psst_pkg;

   // tree geometry
   localparam int MAX_LEAVES = 1024;
   localparam int VALUE_BITS = 16;
   localparam int LEAF_BITS  = $clog2(MAX_LEAVES);
   localparam int NODE_BITS  = LEAF_BITS + 1;
   localparam int NODE_COUNT = 2 * MAX_LEAVES - 1;
   localparam int SUM_BITS   = VALUE_BITS + LEAF_BITS;
   localparam int COUNT_BITS = 11;
   localparam int TARGET_BITS = 32;

   localparam logic [NODE_BITS-1:0]  LEAF_BASE = NODE_BITS'(MAX_LEAVES - 1);
   localparam logic [NODE_BITS-1:0]  NODE_LAST = NODE_BITS'(NODE_COUNT - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(MAX_LEAVES);

   // operation codes
   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   // input beat
   typedef struct packed {
      logic                          op;
      logic [10:0]                   index;
      logic [15:0]                   value;
      logic signed [TARGET_BITS-1:0] target;
   } req_type;

   // result beat
   typedef struct packed {
      logic       accepted;
      logic       found;
      logic [9:0] position;
   } rsp_type;

   // node store access
   typedef struct packed {
      logic                 wr_en;
      logic [NODE_BITS-1:0] wr_addr;
      logic [SUM_BITS-1:0]  wr_data;
      logic [NODE_BITS-1:0] rd_addr;
   } ram_cmd_type;

   // shared add / subtract unit result
   typedef struct packed {
      logic [SUM_BITS-1:0] sum;
      logic                neg;
      logic                zero;
   } step_res_type;

endpackage

[rtl/core/prefix_sum_search_tree.sv]
// ----------------------------------------------------------------------------
// prefix_sum_search_tree
// sum segment tree over 1024 leaves with prefix lower-bound search
//
//   channel  direction  handshake        beat
//   req      in         valid / stall    op, index, value, target
//   rsp      out        valid / stall    accepted, found, position
//   csr      in         valid / ready    leaf_count write data
//
// an update or query reads the node store once per tree level, plus entry
// and reply. a refused update or a negative or oversized target goes
// straight to reply, a target above the tree total after the root check.
// reset and every csr write clear every node store entry, req stalled.
// a stalled result holds the output register; the next item runs on and
// waits in its reply state until that beat is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prefix_sum_search_tree (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  psst_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output psst_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [psst_pkg::COUNT_BITS-1:0] csr_wdata
);
   import psst_pkg::*;

   `include "prefix_sum_search_tree_assert.svh"

   typedef enum logic [6:0] {
      ST_CLEAR    = 7'b0000001,
      ST_IDLE     = 7'b0000010,
      ST_UPD_LEAF = 7'b0000100,
      ST_UPD_WALK = 7'b0001000,
      ST_QRY_ROOT = 7'b0010000,
      ST_QRY_WALK = 7'b0100000,
      ST_REPLY    = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [NODE_BITS-1:0]  clr_addr_ff, clr_addr_in;
   logic [COUNT_BITS-1:0] leaf_count_ff, leaf_count_in;
   logic [NODE_BITS-1:0]  node_ff, node_in;
   logic [SUM_BITS-1:0]   acc_ff, acc_in;
   rsp_type               res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   ram_cmd_type           ram_cmd;
   logic [SUM_BITS-1:0]   ram_rd_data;
   step_res_type          step;
   logic                  step_sub;
   logic                  csr_write;
   logic                  req_take;
   logic                  rsp_free;
   logic [NODE_BITS-1:0]  parent;
   logic [NODE_BITS-1:0]  child_left;
   logic [NODE_BITS-1:0]  child_next;

   function automatic logic [NODE_BITS-1:0] sibling_of(input logic [NODE_BITS-1:0] n);
      return n[0] ? n + NODE_BITS'(1) : n - NODE_BITS'(1);
   endfunction

   // node store and shared unit
   psst_node_ram u_ram (
      .clock   (clock),
      .cmd     (ram_cmd),
      .rd_data (ram_rd_data)
   );

   psst_step_unit u_step (
      .acc     (acc_ff),
      .operand (ram_rd_data),
      .sub     (step_sub),
      .res     (step)
   );

   assign step_sub  = (state_ff == ST_QRY_ROOT) || (state_ff == ST_QRY_WALK);
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // tree navigation
   always_comb begin
      parent     = (node_ff - NODE_BITS'(1)) >> 1;
      child_left = {node_ff[LEAF_BITS-1:0], 1'b1};
      child_next = step.neg | step.zero ? child_left : child_left + NODE_BITS'(1);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      leaf_count_in = leaf_count_ff;
      node_in       = node_ff;
      acc_in        = acc_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_data_in   = rsp_data_ff;
      ram_cmd       = '0;

      case (state_ff)
         ST_CLEAR: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = clr_addr_ff;
            clr_addr_in     = clr_addr_ff + NODE_BITS'(1);
            if (clr_addr_ff == NODE_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // root read runs every idle cycle for a query
            if (req_take) begin
               res_in = '0;
               if (req_data.op == OP_UPDATE) begin
                  node_in = NODE_BITS'(req_data.index[LEAF_BITS-1:0]) + LEAF_BASE;
                  acc_in  = SUM_BITS'(req_data.value);
                  if (req_data.index < leaf_count_ff) begin
                     state_in = ST_UPD_LEAF;
                  end else begin
                     state_in = ST_REPLY;
                  end
               end else begin
                  acc_in       = req_data.target[SUM_BITS-1:0];
                  res_in.accepted = 1'b1;
                  if (req_data.target[TARGET_BITS-1:SUM_BITS] != '0) begin
                     state_in = ST_REPLY;
                  end else begin
                     state_in = ST_QRY_ROOT;
                  end
               end
            end
         end
         ST_UPD_LEAF: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = node_ff;
            ram_cmd.wr_data = acc_ff;
            ram_cmd.rd_addr = sibling_of(node_ff);
            state_in        = ST_UPD_WALK;
         end
         ST_UPD_WALK: begin
            // parent takes own sum plus sibling sum
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = parent;
            ram_cmd.wr_data = step.sum;
            ram_cmd.rd_addr = sibling_of(parent);
            acc_in          = step.sum;
            node_in         = parent;
            if (parent == '0) begin
               res_in.accepted = 1'b1;
               state_in        = ST_REPLY;
            end
         end
         ST_QRY_ROOT: begin
            // target above total means no prefix reaches it
            if (!(step.neg || step.zero)) begin
               state_in = ST_REPLY;
            end else begin
               node_in         = '0;
               ram_cmd.rd_addr = NODE_BITS'(1);
               state_in        = ST_QRY_WALK;
            end
         end
         ST_QRY_WALK: begin
            node_in = child_next;
            if (!(step.neg || step.zero)) begin
               acc_in = step.sum;
            end
            ram_cmd.rd_addr = {child_next[LEAF_BITS-1:0], 1'b1};
            if (child_next >= LEAF_BASE) begin
               res_in.found    = 1'b1;
               res_in.position = LEAF_BITS'(child_next - LEAF_BASE);
               state_in        = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      // leaf count write resizes and clears the tree
      if (csr_write) begin
         state_in    = ST_CLEAR;
         clr_addr_in = '0;
         if (csr_wdata == '0) begin
            leaf_count_in = COUNT_BITS'(1);
         end else if (csr_wdata > COUNT_MAX) begin
            leaf_count_in = COUNT_MAX;
         end else begin
            leaf_count_in = csr_wdata;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         leaf_count_ff <= COUNT_MAX;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         leaf_count_ff <= leaf_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      acc_ff      <= acc_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // checks
   `PSST_ASSERT_NOW(a_walk_internal, clock, reset, state_ff == ST_QRY_WALK, node_ff < LEAF_BASE, "query walk reached a leaf node")
   `PSST_ASSERT_NOW(a_query_no_write, clock, reset, state_ff == ST_QRY_ROOT || state_ff == ST_QRY_WALK, !ram_cmd.wr_en, "node store written during a query")
   `PSST_ASSERT_NEXT(a_clear_ends, clock, reset, state_ff == ST_CLEAR && clr_addr_ff == NODE_LAST && !csr_write, state_ff == ST_IDLE, "clearing pass did not finish")

endmodule

[rtl/core/psst_node_ram.sv]
// ----------------------------------------------------------------------------
// psst_node_ram
// node sum store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psst_node_ram (
   input  logic                          clock,
   input  psst_pkg::ram_cmd_type         cmd,
   output logic [psst_pkg::SUM_BITS-1:0] rd_data
);
   import psst_pkg::*;

   logic [SUM_BITS-1:0] mem_ff [NODE_COUNT];
   logic [SUM_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.wr_addr] <= cmd.wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[cmd.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/psst_step_unit.sv]
// ----------------------------------------------------------------------------
// psst_step_unit
// shared adder: sums sibling pairs on update, subtracts and compares on query
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psst_step_unit (
   input  logic [psst_pkg::SUM_BITS-1:0] acc,
   input  logic [psst_pkg::SUM_BITS-1:0] operand,
   input  logic                          sub,
   output psst_pkg::step_res_type        res
);
   import psst_pkg::*;

   logic [SUM_BITS:0] opnd_ext;
   logic [SUM_BITS:0] total;

   // one add with optional invert and carry in
   always_comb begin
      opnd_ext  = sub ? ~{1'b0, operand} : {1'b0, operand};
      total     = {1'b0, acc} + opnd_ext + {{SUM_BITS{1'b0}}, sub};
      res.sum   = total[SUM_BITS-1:0];
      res.neg   = sub & total[SUM_BITS];
      res.zero  = (total[SUM_BITS-1:0] == '0);
   end

endmodule
